// File: design/rhs_pkg.sv
// Shared types, codes and constants for the ring history store.
package rhs_pkg;

    // Default sizing.
    localparam int DEF_MAX_DEPTH    = 32;
    localparam int DEF_MAX_COUNTERS = 8;
    localparam int DEF_COUNTERS     = 8;
    localparam int DEF_DEPTH        = 32;

    // Depths of the command queue between front and back and of the result queue.
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    // Field widths covering the full parameter ranges.
    localparam int SLOT_MAX_W = 6;
    localparam int CNT_MAX_W  = 4;
    localparam int LEN_MAX_W  = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTERS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 4'd1;

    // Input actions.
    localparam logic [1:0] ACT_START    = 2'd0;
    localparam logic [1:0] ACT_PUSH     = 2'd1;
    localparam logic [1:0] ACT_READ_REC = 2'd2;
    localparam logic [1:0] ACT_READ_COL = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_TIME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_OPEN  = 2'd2;

    // Command opcodes.
    localparam logic [2:0] CMD_WR_TIME  = 3'd0;
    localparam logic [2:0] CMD_WR_VALUE = 3'd1;
    localparam logic [2:0] CMD_RD_REC   = 3'd2;
    localparam logic [2:0] CMD_RD_COL   = 3'd3;
    localparam logic [2:0] CMD_ERROR    = 3'd4;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [63:0] time_stamp;
        logic signed [63:0] sample_value;
        logic [4:0]         target_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         item_kind;
        logic signed [63:0] payload;
        logic [5:0]         run_position;
        logic [5:0]         entries_held;
        logic [1:0]         error_code;
        logic               last_item;
    } t_out_item;

    typedef struct packed {
        logic [2:0]            op;
        logic [SLOT_MAX_W-1:0] slot;
        logic [CNT_MAX_W-1:0]  cnt;
        logic [63:0]           data;
        logic [LEN_MAX_W-1:0]  len;
        logic [LEN_MAX_W-1:0]  depth;
        logic [5:0]            entries;
        logic [1:0]            err;
    } t_cmd;

endpackage

// File: design/rhs_ram.sv
// Generic simple dual-port RAM with registered read.
module rhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/rhs_fifo.sv
// Small register FIFO used for the command queue and the result queue.
module rhs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_count = r_count;

endmodule

// File: design/rhs_front.sv
// Front end: takes items and config writes, keeps ring pointers, issues commands.
module rhs_front #(
    parameter int MAX_DEPTH    = rhs_pkg::DEF_MAX_DEPTH,
    parameter int MAX_COUNTERS = rhs_pkg::DEF_MAX_COUNTERS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  rhs_pkg::t_in_item                i_in_data,
    input  logic                             i_cfg_valid,
    input  logic [rhs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rhs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_cmd_push,
    output rhs_pkg::t_cmd                    o_cmd,
    input  logic                             i_cmd_full
);

    localparam int SLOT_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int DEP_W  = $clog2(MAX_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_COUNTERS + 1);
    localparam int SUM_W  = DEP_W + 1;
    localparam int CMP_W  = 7;
    localparam int CIN_RST = (rhs_pkg::DEF_COUNTERS > MAX_COUNTERS) ?
                             MAX_COUNTERS : rhs_pkg::DEF_COUNTERS;
    localparam int DEP_RST = (rhs_pkg::DEF_DEPTH > MAX_DEPTH) ?
                             MAX_DEPTH : rhs_pkg::DEF_DEPTH;

    logic [CNT_W-1:0]  r_cin, n_cin;
    logic [DEP_W-1:0]  r_depth, n_depth;
    logic [SLOT_W-1:0] r_wp, n_wp;
    logic [DEP_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_pend, n_pend;
    logic              r_open, n_open;

    logic              accept;
    logic [DEP_W-1:0]  wp_inc;
    logic [SLOT_W-1:0] wp_wrap;
    logic [DEP_W-1:0]  fill_inc;
    logic [CNT_W-1:0]  pend_inc;
    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  rec_sum;
    logic [SUM_W-1:0]  rec_slot;
    logic [SUM_W-1:0]  col_slot;
    logic [3:0]        cfg_cnt;
    logic [5:0]        cfg_dep;
    logic [4:0]        idx;

    // A config write takes the cycle, so the input is held off for it.
    assign o_in_stall = i_cmd_full || i_cfg_valid;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_cin   = r_cin;
        n_depth = r_depth;
        n_wp    = r_wp;
        n_fill  = r_fill;
        n_pend  = r_pend;
        n_open  = r_open;
        o_cmd_push = 1'b0;
        o_cmd      = '0;

        idx     = i_in_data.target_index;
        cfg_cnt = i_cfg_data[3:0];
        cfg_dep = i_cfg_data[5:0];

        wp_inc   = DEP_W'(r_wp) + 1'b1;
        wp_wrap  = (wp_inc == r_depth) ? '0 : SLOT_W'(wp_inc);
        fill_inc = (r_fill < r_depth) ? r_fill + 1'b1 : r_fill;
        pend_inc = r_pend + 1'b1;

        // Oldest held record sits fill entries behind the write pointer.
        base     = SUM_W'(r_wp) + SUM_W'(r_depth - r_fill);
        rec_sum  = base + SUM_W'(idx);
        rec_slot = (rec_sum >= SUM_W'(r_depth)) ? rec_sum - SUM_W'(r_depth) : rec_sum;
        col_slot = (base >= SUM_W'(r_depth)) ? base - SUM_W'(r_depth) : base;

        o_cmd.entries = 6'(r_fill);
        o_cmd.depth   = rhs_pkg::LEN_MAX_W'(r_depth);
        o_cmd.data    = 64'(i_in_data.time_stamp);

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rhs_pkg::REG_COUNTERS: begin
                    n_cin  = (5'(cfg_cnt) > 5'(MAX_COUNTERS)) ?
                             CNT_W'(MAX_COUNTERS) : CNT_W'(cfg_cnt);
                    n_wp   = '0;
                    n_fill = '0;
                    n_pend = '0;
                    n_open = 1'b0;
                end
                rhs_pkg::REG_DEPTH: begin
                    if (cfg_dep == '0) begin
                        n_depth = DEP_W'(1);
                    end else if (CMP_W'(cfg_dep) > CMP_W'(MAX_DEPTH)) begin
                        n_depth = DEP_W'(MAX_DEPTH);
                    end else begin
                        n_depth = DEP_W'(cfg_dep);
                    end
                    n_wp   = '0;
                    n_fill = '0;
                    n_pend = '0;
                    n_open = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            unique case (i_in_data.action)
                rhs_pkg::ACT_START: begin
                    o_cmd_push = 1'b1;
                    o_cmd.op   = rhs_pkg::CMD_WR_TIME;
                    o_cmd.slot = rhs_pkg::SLOT_MAX_W'(r_wp);
                    n_open = 1'b1;
                    n_pend = '0;
                    if (r_cin == '0) begin
                        n_wp   = wp_wrap;
                        n_fill = fill_inc;
                        n_open = 1'b0;
                    end
                end
                rhs_pkg::ACT_PUSH: begin
                    if (r_open) begin
                        o_cmd_push = 1'b1;
                        o_cmd.op   = rhs_pkg::CMD_WR_VALUE;
                        o_cmd.slot = rhs_pkg::SLOT_MAX_W'(r_wp);
                        o_cmd.cnt  = rhs_pkg::CNT_MAX_W'(r_pend);
                        o_cmd.data = 64'(i_in_data.sample_value);
                        n_pend = pend_inc;
                        if (pend_inc >= r_cin) begin
                            n_wp   = wp_wrap;
                            n_fill = fill_inc;
                            n_open = 1'b0;
                            n_pend = '0;
                        end
                    end
                end
                rhs_pkg::ACT_READ_REC: begin
                    o_cmd_push = 1'b1;
                    if (r_open) begin
                        o_cmd.op  = rhs_pkg::CMD_ERROR;
                        o_cmd.err = rhs_pkg::ERR_OPEN;
                    end else if (CMP_W'(idx) >= CMP_W'(r_fill)) begin
                        o_cmd.op  = rhs_pkg::CMD_ERROR;
                        o_cmd.err = rhs_pkg::ERR_RANGE;
                    end else begin
                        o_cmd.op   = rhs_pkg::CMD_RD_REC;
                        o_cmd.slot = rhs_pkg::SLOT_MAX_W'(rec_slot);
                        o_cmd.len  = rhs_pkg::LEN_MAX_W'(r_cin);
                    end
                end
                rhs_pkg::ACT_READ_COL: begin
                    o_cmd_push = 1'b1;
                    if (r_open) begin
                        o_cmd.op  = rhs_pkg::CMD_ERROR;
                        o_cmd.err = rhs_pkg::ERR_OPEN;
                    end else if (CMP_W'(idx) >= CMP_W'(r_cin) || r_fill == '0) begin
                        o_cmd.op  = rhs_pkg::CMD_ERROR;
                        o_cmd.err = rhs_pkg::ERR_RANGE;
                    end else begin
                        o_cmd.op   = rhs_pkg::CMD_RD_COL;
                        o_cmd.slot = rhs_pkg::SLOT_MAX_W'(col_slot);
                        o_cmd.cnt  = rhs_pkg::CNT_MAX_W'(idx);
                        o_cmd.len  = rhs_pkg::LEN_MAX_W'(r_fill);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cin   <= CNT_W'(CIN_RST);
            r_depth <= DEP_W'(DEP_RST);
            r_wp    <= '0;
            r_fill  <= '0;
            r_pend  <= '0;
            r_open  <= 1'b0;
        end else begin
            r_cin   <= n_cin;
            r_depth <= n_depth;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_open  <= n_open;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_depth)
        else $error("fill level above depth in use");

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DEP_W'(r_wp) < r_depth)
        else $error("write pointer outside ring");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_pend < r_cin))
        else $error("open record holds a full set of counters");
`endif

endmodule

// File: design/rhs_back.sv
// Back end: executes store writes and read runs, queues results for the output.
module rhs_back #(
    parameter int MAX_DEPTH    = rhs_pkg::DEF_MAX_DEPTH,
    parameter int MAX_COUNTERS = rhs_pkg::DEF_MAX_COUNTERS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  rhs_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rhs_pkg::t_out_item    o_out_data
);

    localparam int SLOT_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW     = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;
    localparam int DEP_W  = $clog2(MAX_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_COUNTERS + 1);
    localparam int POS_W  = (DEP_W > CNT_W) ? DEP_W : CNT_W;
    localparam int OQ_W   = $clog2(rhs_pkg::OUT_QUEUE_DEPTH + 1);
    localparam int OCC_W  = OQ_W + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] pos;
        logic       last;
        logic [1:0] err;
        logic [5:0] entries;
    } t_meta;

    logic              r_state, n_state;
    logic              r_col, n_col;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_len, n_len;
    logic [DEP_W-1:0]  r_depth, n_depth;
    logic [5:0]        r_entries, n_entries;
    logic              r_b_valid;
    t_meta             r_b_meta;

    logic              issue;
    logic              can_issue;
    t_meta             meta;
    logic              last_run;
    logic              t_we, v_we;
    logic [SLOT_W-1:0] t_raddr;
    logic [SLOT_W+CW-1:0] v_raddr;
    logic [SLOT_W-1:0] cmd_slot;
    logic [CW-1:0]     cmd_cnt;
    logic [DEP_W-1:0]  cmd_depth;
    logic [63:0]       t_rdata, v_rdata;

    rhs_pkg::t_out_item out_item;
    logic              out_pop, out_empty, out_full;
    logic [OQ_W-1:0]   out_count;
    logic [OCC_W-1:0]  occ;

    function automatic logic [SLOT_W-1:0] f_next(input logic [SLOT_W-1:0] slot,
                                                 input logic [DEP_W-1:0] depth);
        logic [DEP_W-1:0] inc;
        inc = DEP_W'(slot) + 1'b1;
        return (inc == depth) ? '0 : SLOT_W'(inc);
    endfunction

    assign cmd_slot  = SLOT_W'(i_cmd.slot);
    assign cmd_cnt   = CW'(i_cmd.cnt);
    assign cmd_depth = DEP_W'(i_cmd.depth);

    // Results in flight plus queued may not exceed the result queue.
    assign out_pop   = o_out_valid && !i_out_stall;
    assign occ       = OCC_W'(out_count) + OCC_W'(r_b_valid);
    assign can_issue = occ < (OCC_W'(rhs_pkg::OUT_QUEUE_DEPTH) + OCC_W'(out_pop));

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_slot    = r_slot;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_len     = r_len;
        n_depth   = r_depth;
        n_entries = r_entries;
        o_cmd_pop = 1'b0;
        issue     = 1'b0;
        meta      = '0;
        t_we      = 1'b0;
        v_we      = 1'b0;
        last_run  = 1'b0;
        t_raddr   = cmd_slot;
        v_raddr   = {r_slot, r_cnt};

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        rhs_pkg::CMD_WR_TIME: begin
                            o_cmd_pop = 1'b1;
                            t_we      = 1'b1;
                        end
                        rhs_pkg::CMD_WR_VALUE: begin
                            o_cmd_pop = 1'b1;
                            v_we      = 1'b1;
                        end
                        rhs_pkg::CMD_ERROR: begin
                            if (can_issue) begin
                                o_cmd_pop    = 1'b1;
                                issue        = 1'b1;
                                meta.kind    = rhs_pkg::KIND_ERROR;
                                meta.last    = 1'b1;
                                meta.err     = i_cmd.err;
                                meta.entries = i_cmd.entries;
                            end
                        end
                        rhs_pkg::CMD_RD_REC: begin
                            if (can_issue) begin
                                o_cmd_pop    = 1'b1;
                                issue        = 1'b1;
                                meta.kind    = rhs_pkg::KIND_TIME;
                                meta.last    = (i_cmd.len == '0);
                                meta.entries = i_cmd.entries;
                                if (i_cmd.len != '0) begin
                                    n_state   = ST_RUN;
                                    n_col     = 1'b0;
                                    n_slot    = cmd_slot;
                                    n_cnt     = '0;
                                    n_pos     = POS_W'(1);
                                    n_len     = POS_W'(i_cmd.len);
                                    n_entries = i_cmd.entries;
                                end
                            end
                        end
                        rhs_pkg::CMD_RD_COL: begin
                            v_raddr = {cmd_slot, cmd_cnt};
                            if (can_issue) begin
                                o_cmd_pop    = 1'b1;
                                issue        = 1'b1;
                                meta.kind    = rhs_pkg::KIND_VALUE;
                                meta.last    = (i_cmd.len == rhs_pkg::LEN_MAX_W'(1));
                                meta.entries = i_cmd.entries;
                                if (i_cmd.len != rhs_pkg::LEN_MAX_W'(1)) begin
                                    n_state   = ST_RUN;
                                    n_col     = 1'b1;
                                    n_slot    = f_next(cmd_slot, cmd_depth);
                                    n_cnt     = cmd_cnt;
                                    n_pos     = POS_W'(1);
                                    n_len     = POS_W'(i_cmd.len);
                                    n_depth   = cmd_depth;
                                    n_entries = i_cmd.entries;
                                end
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (can_issue) begin
                    issue        = 1'b1;
                    meta.kind    = rhs_pkg::KIND_VALUE;
                    meta.pos     = 6'(r_pos);
                    meta.entries = r_entries;
                    // A record run ends on its last counter, a column on its newest record.
                    if (r_col) begin
                        last_run = ((r_pos + 1'b1) == r_len);
                        n_slot   = f_next(r_slot, r_depth);
                    end else begin
                        last_run = (r_pos == r_len);
                        n_cnt    = r_cnt + 1'b1;
                    end
                    meta.last = last_run;
                    n_pos     = r_pos + 1'b1;
                    if (last_run) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_b_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_b_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col     <= n_col;
        r_slot    <= n_slot;
        r_cnt     <= n_cnt;
        r_pos     <= n_pos;
        r_len     <= n_len;
        r_depth   <= n_depth;
        r_entries <= n_entries;
        r_b_meta  <= meta;
    end

    rhs_ram #(
        .WIDTH (64),
        .DEPTH (2 ** SLOT_W)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (cmd_slot),
        .i_wdata (i_cmd.data),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    rhs_ram #(
        .WIDTH (64),
        .DEPTH (2 ** (SLOT_W + CW))
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr ({cmd_slot, cmd_cnt}),
        .i_wdata (i_cmd.data),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    always_comb begin
        out_item.item_kind    = r_b_meta.kind;
        out_item.run_position = r_b_meta.pos;
        out_item.entries_held = r_b_meta.entries;
        out_item.error_code   = r_b_meta.err;
        out_item.last_item    = r_b_meta.last;
        case (r_b_meta.kind)
            rhs_pkg::KIND_TIME:  out_item.payload = t_rdata;
            rhs_pkg::KIND_VALUE: out_item.payload = v_rdata;
            default:             out_item.payload = '0;
        endcase
    end

    rhs_fifo #(
        .WIDTH ($bits(rhs_pkg::t_out_item)),
        .DEPTH (rhs_pkg::OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_b_valid),
        .i_data  (out_item),
        .i_pop   (out_pop),
        .o_data  (o_out_data),
        .o_empty (out_empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

    assign o_out_valid = !out_empty;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ <= OCC_W'(rhs_pkg::OUT_QUEUE_DEPTH))
        else $error("results in flight exceed result queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (!out_full || out_pop))
        else $error("read data arrives at a full result queue");

    a_run_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_pos <= r_len))
        else $error("read run position beyond run length");
`endif

endmodule

// File: design/ring_history_store.sv
// Ring history store: circular log of time-stamped counter records.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one transfer per cycle
// while o_in_stall is low. Start-record and push-value items write the store
// and give no result; read-record and read-column items give a run of results.
// Output channel (o_out_valid / i_out_stall / o_out_data): one result per
// transfer, last_item marks the end of a read run.
// Config channel (i_cfg_valid / o_cfg_ready): always ready, holds off input in
// that cycle; a write to either register empties the log. Write only when idle.
// A read's first result passes the command queue, the registered store read and
// the result queue. Appends sustain one item per cycle while o_in_stall is low.
// A read holds the back end until its results are issued: counters_in_use + 1
// for a record, entries held for a column, paced by the single read port of each
// store RAM. Later items wait in a 4-entry command queue, then o_in_stall rises.
// Reset: pointers, fill level and open record clear at once, the registers
// return to 8 counters and 32 records; the store RAMs are not cleared.
// When the receiver stalls, a 2-entry result queue fills and the read run
// pauses in place; nothing is dropped.
module ring_history_store #(
    parameter int MAX_DEPTH    = rhs_pkg::DEF_MAX_DEPTH,
    parameter int MAX_COUNTERS = rhs_pkg::DEF_MAX_COUNTERS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  rhs_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output rhs_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rhs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rhs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CQ_CNT_W = $clog2(rhs_pkg::CMD_QUEUE_DEPTH + 1);

    rhs_pkg::t_cmd       front_cmd;
    rhs_pkg::t_cmd       back_cmd;
    logic                cmd_push;
    logic                cmd_pop;
    logic                cmd_empty;
    logic                cmd_full;
    logic [CQ_CNT_W-1:0] cmd_count;

    assign o_cfg_ready = 1'b1;

    rhs_front #(
        .MAX_DEPTH    (MAX_DEPTH),
        .MAX_COUNTERS (MAX_COUNTERS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_push  (cmd_push),
        .o_cmd       (front_cmd),
        .i_cmd_full  (cmd_full)
    );

    rhs_fifo #(
        .WIDTH ($bits(rhs_pkg::t_cmd)),
        .DEPTH (rhs_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty),
        .o_full  (cmd_full),
        .o_count (cmd_count)
    );

    rhs_back #(
        .MAX_DEPTH    (MAX_DEPTH),
        .MAX_COUNTERS (MAX_COUNTERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_cmd_queue_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_push |-> !cmd_full) and (cmd_pop |-> (cmd_count != '0)))
        else $error("command queue overflow or underflow");
`endif

endmodule

// File: bench/ring_history_store_tb.sv
// Self-checking bench for the ring history store: directed cases and random record traffic checked against a predictor.
`timescale 1ns / 100ps
module ring_history_store_tb;

    localparam int IDLE_LIMIT = 1000;
    localparam int SETTLE     = 20;
    localparam int NPHASE     = 6;
    localparam logic [rhs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd15;
    localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;

    localparam int PHASE_COUNTERS [NPHASE] = '{1, 8, 2, 15, 0, 5};
    localparam int PHASE_DEPTH    [NPHASE] = '{32, 5, 1, 3, 7, 63};
    localparam int PHASE_ITEMS    [NPHASE] = '{30, 12, 10, 12, 10, 12};

    // Mirror of the log contents plus the queue of read results still owed.
    class history_scoreboard;
        logic [63:0] stamps [rhs_pkg::DEF_MAX_DEPTH];
        logic [63:0] values [rhs_pkg::DEF_MAX_DEPTH*rhs_pkg::DEF_MAX_COUNTERS];
        int unsigned wr_ptr, fill, pending, counters, depth;
        bit          rec_open;
        rhs_pkg::t_out_item expected_reads[$];
        int          mismatches, failures;

        function new();
            counters   = rhs_pkg::DEF_COUNTERS;
            depth      = rhs_pkg::DEF_DEPTH;
            mismatches = 0;
            failures   = 0;
            clear_log();
        endfunction

        function void clear_log();
            wr_ptr   = 0;
            fill     = 0;
            pending  = 0;
            rec_open = 1'b0;
        endfunction

        function void commit();
            wr_ptr = (wr_ptr + 1) % depth;
            if (fill < depth) fill++;
            rec_open = 1'b0;
            pending  = 0;
        endfunction

        function void write_reg(logic [rhs_pkg::CFG_IDX_W-1:0] idx,
                                logic [rhs_pkg::CFG_DATA_W-1:0] data);
            int unsigned v;
            if (idx == rhs_pkg::REG_COUNTERS) begin
                v = 32'(data[3:0]);
                counters = (v > rhs_pkg::DEF_MAX_COUNTERS) ? rhs_pkg::DEF_MAX_COUNTERS : v;
            end else if (idx == rhs_pkg::REG_DEPTH) begin
                v = 32'(data);
                if (v == 0) v = 1;
                depth = (v > rhs_pkg::DEF_MAX_DEPTH) ? rhs_pkg::DEF_MAX_DEPTH : v;
            end else begin
                return;
            end
            clear_log();
        endfunction

        function void queue_result(logic [1:0] kind, logic [63:0] payload, int unsigned pos,
                                   logic [1:0] err, bit last);
            rhs_pkg::t_out_item r;
            r.item_kind    = kind;
            r.payload      = payload;
            r.run_position = pos[5:0];
            r.entries_held = fill[5:0];
            r.error_code   = err;
            r.last_item    = last;
            expected_reads.push_back(r);
        endfunction

        function void note_item(rhs_pkg::t_in_item it);
            int unsigned idx, slot, first, i;
            idx = 32'(it.target_index);
            if (it.action == rhs_pkg::ACT_START) begin
                stamps[wr_ptr] = it.time_stamp;
                rec_open = 1'b1;
                pending  = 0;
                if (counters == 0) commit();
            end else if (it.action == rhs_pkg::ACT_PUSH) begin
                if (rec_open) begin
                    if (pending < rhs_pkg::DEF_MAX_COUNTERS)
                        values[wr_ptr*rhs_pkg::DEF_MAX_COUNTERS + pending] = it.sample_value;
                    pending++;
                    if (pending >= counters) commit();
                end
            end else if (rec_open) begin
                queue_result(rhs_pkg::KIND_ERROR, '0, 0, rhs_pkg::ERR_OPEN, 1'b1);
            end else if (it.action == rhs_pkg::ACT_READ_REC) begin
                if (idx >= fill) begin
                    queue_result(rhs_pkg::KIND_ERROR, '0, 0, rhs_pkg::ERR_RANGE, 1'b1);
                end else begin
                    slot = (wr_ptr + depth - fill + idx) % depth;
                    queue_result(rhs_pkg::KIND_TIME, stamps[slot], 0, rhs_pkg::ERR_OK,
                                 counters == 0);
                    for (i = 0; i < counters; i++)
                        queue_result(rhs_pkg::KIND_VALUE,
                                     values[slot*rhs_pkg::DEF_MAX_COUNTERS + i], i + 1,
                                     rhs_pkg::ERR_OK, i + 1 == counters);
                end
            end else begin
                if (idx >= counters || fill == 0) begin
                    queue_result(rhs_pkg::KIND_ERROR, '0, 0, rhs_pkg::ERR_RANGE, 1'b1);
                end else begin
                    first = (wr_ptr + depth - fill) % depth;
                    for (i = 0; i < fill; i++) begin
                        slot = (first + i) % depth;
                        queue_result(rhs_pkg::KIND_VALUE,
                                     values[slot*rhs_pkg::DEF_MAX_COUNTERS + idx], i,
                                     rhs_pkg::ERR_OK, i + 1 == fill);
                    end
                end
            end
        endfunction

        function void check_result(rhs_pkg::t_out_item got);
            rhs_pkg::t_out_item want;
            if (expected_reads.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind=%0d payload=%h pos=%0d held=%0d err=%0d last=%0d",
                             got.item_kind, got.payload, got.run_position, got.entries_held,
                             got.error_code, got.last_item);
                return;
            end
            want = expected_reads.pop_front();
            if (got.item_kind !== want.item_kind || got.payload !== want.payload ||
                got.run_position !== want.run_position ||
                got.entries_held !== want.entries_held ||
                got.error_code !== want.error_code || got.last_item !== want.last_item) begin
                failures++;
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  exp kind=%0d payload=%h pos=%0d held=%0d err=%0d last=%0d",
                             want.item_kind, want.payload, want.run_position,
                             want.entries_held, want.error_code, want.last_item);
                    $display("  got kind=%0d payload=%h pos=%0d held=%0d err=%0d last=%0d",
                             got.item_kind, got.payload, got.run_position,
                             got.entries_held, got.error_code, got.last_item);
                end
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    rhs_pkg::t_in_item               in_data;
    logic                            out_valid;
    logic                            out_stall;
    rhs_pkg::t_out_item              out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [rhs_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [rhs_pkg::CFG_DATA_W-1:0]  cfg_data;

    history_scoreboard sb;
    bit                calm;
    int unsigned       items_sent;

    ring_history_store i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic rhs_pkg::t_in_item make_item(logic [1:0] act, logic [63:0] ts,
                                                    logic [63:0] sv, logic [4:0] idx);
        rhs_pkg::t_in_item it;
        it.action       = act;
        it.time_stamp   = ts;
        it.sample_value = sv;
        it.target_index = idx;
        return it;
    endfunction

    task automatic send_item(input rhs_pkg::t_in_item it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge clk); while (in_stall);
        // a push with no record open is dropped by the block, so it is not counted
        if (!(it.action == rhs_pkg::ACT_PUSH && !sb.rec_open)) items_sent++;
        sb.note_item(it);
    endtask

    // Brings the log idle before the write: drain owed results, then let appends settle.
    task automatic write_reg(input logic [rhs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rhs_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_reads.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic append_record(input logic [63:0] ts, input bit cut_short);
        int unsigned n;
        send_item(make_item(rhs_pkg::ACT_START, ts, rand64(), 5'($urandom_range(0, 31))));
        n = sb.counters;
        if (cut_short && n > 0) n = $urandom_range(0, n - 1);
        repeat (n) send_item(make_item(rhs_pkg::ACT_PUSH, rand64(), rand64(),
                                       5'($urandom_range(0, 31))));
    endtask

    task automatic random_step(input bit dense);
        int unsigned pick;
        logic [4:0]  idx;
        pick = $urandom_range(0, dense ? 39 : 9);
        if (pick >= 10) pick = 0;
        case (pick)
            0, 1, 2, 3, 4: append_record(rand64(), $urandom_range(0, 7) == 0);
            5: send_item(make_item(rhs_pkg::ACT_PUSH, rand64(), rand64(),
                                   5'($urandom_range(0, 31))));
            6: begin
                idx = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, sb.fill));
                send_item(make_item(rhs_pkg::ACT_READ_REC, rand64(), rand64(), idx));
            end
            7: begin
                idx = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, sb.counters));
                send_item(make_item(rhs_pkg::ACT_READ_COL, rand64(), rand64(), idx));
            end
            default: send_item(make_item(2'($urandom_range(0, 3)), rand64(), rand64(),
                                         5'($urandom_range(0, 31))));
        endcase
    endtask

    initial begin : result_sink
        int hold;
        wait (rst_n === 1'b1);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 15);
            @(negedge clk);
            if (hold > 0) begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
                out_stall = 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int unsigned p, budget;
        sb         = new();
        calm       = 1'b0;
        items_sent = 0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = rhs_pkg::REG_COUNTERS;
        cfg_data   = '0;
        rst_n      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: 8 counters, 32 records
        send_item(make_item(rhs_pkg::ACT_READ_REC, '0, '0, 5'd0));  // empty log, record read
        send_item(make_item(rhs_pkg::ACT_READ_COL, '0, '0, 5'd0));  // empty log, column read
        send_item(make_item(rhs_pkg::ACT_PUSH, '0, VAL_MAX, 5'd0)); // no record open: dropped
        send_item(make_item(rhs_pkg::ACT_START, VAL_MIN, '0, 5'd0));
        send_item(make_item(rhs_pkg::ACT_PUSH, '1, VAL_MAX, 5'd31));
        send_item(make_item(rhs_pkg::ACT_PUSH, '0, VAL_MIN, 5'd0));
        send_item(make_item(rhs_pkg::ACT_PUSH, '0, '1, 5'd0));
        send_item(make_item(rhs_pkg::ACT_READ_REC, '0, '0, 5'd0));  // record still open
        send_item(make_item(rhs_pkg::ACT_READ_COL, '0, '0, 5'd3));
        for (p = 0; p < 5; p++)
            send_item(make_item(rhs_pkg::ACT_PUSH, '0, 64'(p), 5'd0));
        send_item(make_item(rhs_pkg::ACT_READ_REC, '1, '1, 5'd0));
        send_item(make_item(rhs_pkg::ACT_READ_COL, '0, '0, 5'd7));
        send_item(make_item(rhs_pkg::ACT_READ_COL, '0, '0, 5'd8));  // counter beyond those in use
        send_item(make_item(rhs_pkg::ACT_READ_REC, '0, '0, 5'd31)); // age beyond fill

        // no counters: each start commits on its own; depth above the maximum
        write_reg(rhs_pkg::REG_COUNTERS, '0);
        write_reg(rhs_pkg::REG_DEPTH, '1);
        send_item(make_item(rhs_pkg::ACT_START, VAL_MAX, '0, 5'd0));
        send_item(make_item(rhs_pkg::ACT_START, 64'h0123_4567_89ab_cdef, '0, 5'd0));
        send_item(make_item(rhs_pkg::ACT_READ_REC, '0, '0, 5'd1));
        send_item(make_item(rhs_pkg::ACT_READ_COL, '0, '0, 5'd0));

        // depth of zero acts as one; a second start restarts the open record
        write_reg(rhs_pkg::REG_COUNTERS, 6'd1);
        write_reg(rhs_pkg::REG_DEPTH, '0);
        send_item(make_item(rhs_pkg::ACT_START, 64'd17, '0, 5'd0));
        send_item(make_item(rhs_pkg::ACT_START, 64'd42, '0, 5'd0));
        send_item(make_item(rhs_pkg::ACT_PUSH, '0, 64'hdead_beef_0000_0001, 5'd0));
        send_item(make_item(rhs_pkg::ACT_READ_REC, '0, '0, 5'd0));

        for (p = 0; p < NPHASE; p++) begin
            write_reg(rhs_pkg::REG_COUNTERS, rhs_pkg::CFG_DATA_W'(PHASE_COUNTERS[p]));
            write_reg(rhs_pkg::REG_DEPTH, rhs_pkg::CFG_DATA_W'(PHASE_DEPTH[p]));
            calm   = (p % 3 == 2);
            budget = items_sent + PHASE_ITEMS[p];
            while (items_sent < budget) random_step(p == 0);
            if (p == 0) begin
                // unmapped index: the log must survive it
                write_reg(REG_UNUSED, '1);
                send_item(make_item(rhs_pkg::ACT_READ_COL, rand64(), rand64(), 5'd0));
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_reads.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.expected_reads.size() != 0) begin
            $display("%0d results never arrived", sb.expected_reads.size());
            sb.failures += sb.expected_reads.size();
        end
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
